[rtl/rtpvp_pkg.sv]
// ----------------------------------------------------------------------------
// rtpvp_pkg
// Shared types and constants for the RTP video line packetizer.
// ----------------------------------------------------------------------------
`default_nettype none

package rtpvp_pkg;

  localparam int unsigned HDR_LEN     = 20;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0]  RTP_VERSION_BYTE = 8'h80;
  localparam logic [15:0] MTU_MIN_BYTES    = 16'd40;
  localparam logic [15:0] MTU_OVERHEAD     = 16'd32;
  localparam logic [15:0] DEFAULT_PAYLOAD  = 16'd1200;

  localparam logic [6:0]  RST_PAYLOAD_TYPE = 7'd96;
  localparam logic [31:0] RST_SSRC         = 32'd0;
  localparam logic [15:0] RST_MTU_BYTES    = 16'd1500;
  localparam logic [15:0] RST_LINE_BYTES   = 16'd4800;
  localparam logic [15:0] RST_FRAME_LINES  = 16'd1080;

  typedef enum logic [2:0] {
    CFG_PAYLOAD_TYPE = 3'd0,
    CFG_SSRC         = 3'd1,
    CFG_MTU_BYTES    = 3'd2,
    CFG_LINE_BYTES   = 3'd3,
    CFG_FRAME_LINES  = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [6:0]  payload_type;
    logic [31:0] sync_source_id;
    logic [15:0] mtu_bytes;
    logic [15:0] line_bytes;
    logic [15:0] frame_lines;
  } cfg_t;

  // one accepted video byte, classified
  typedef struct packed {
    logic [7:0]  pixel;
    logic        start;       // byte opens a chunk: header goes first
    logic        last;        // byte closes its chunk
    logic        frame_last;  // byte closes the frame's last chunk
    logic        marker;
    logic [15:0] seq;
    logic [31:0] timestamp;
    logic [15:0] len;
    logic [14:0] line;
    logic [14:0] offset;
  } cmd_t;

endpackage

`default_nettype wire

[rtl/rtpvp_front.sv]
// ----------------------------------------------------------------------------
// rtpvp_front
// Tracks line, offset, chunk and sequence state; tags each input byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpvp_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire rtpvp_pkg::cfg_t cfg,
  input  wire logic          pixel_valid,
  output logic               pixel_ready,
  input  wire logic [7:0]    pixel_byte,
  input  wire logic [31:0]   frame_time,
  output logic               push_valid,
  input  wire logic          push_ready,
  output rtpvp_pkg::cmd_t    push_data
);

  logic [15:0] sequence_number;
  logic [15:0] line_index;
  logic [15:0] line_offset;
  logic [15:0] chunk_bytes_left;
  logic [31:0] latched_timestamp;
  logic        chunk_marker;

  logic [15:0] lb, fl, limit;
  logic        off_wrap, idx_wrap, start, accept;
  logic [15:0] idx_a, off_a, idx_b, off_b;
  logic [15:0] remaining, len;
  logic        marker_new, marker_eff;
  logic [31:0] ts_new;
  logic [15:0] cl_after, off_eff, idx_eff;

  always_comb begin
    lb    = (cfg.line_bytes == 16'd0) ? 16'd1 : cfg.line_bytes;
    fl    = (cfg.frame_lines == 16'd0) ? 16'd1 : cfg.frame_lines;
    limit = (cfg.mtu_bytes > rtpvp_pkg::MTU_MIN_BYTES) ?
            cfg.mtu_bytes - rtpvp_pkg::MTU_OVERHEAD : rtpvp_pkg::DEFAULT_PAYLOAD;

    off_wrap = line_offset >= lb;
    idx_a    = off_wrap ? line_index + 16'd1 : line_index;
    off_a    = off_wrap ? 16'd0 : line_offset;
    idx_wrap = idx_a >= fl;
    idx_b    = idx_wrap ? 16'd0 : idx_a;
    off_b    = idx_wrap ? 16'd0 : off_a;

    remaining  = lb - off_b;
    len        = (remaining < limit) ? remaining : limit;
    marker_new = (idx_b == fl - 16'd1) && (remaining <= limit);
    ts_new     = (idx_b == 16'd0 && off_b == 16'd0) ? frame_time : latched_timestamp;

    start      = chunk_bytes_left == 16'd0;
    cl_after   = (start ? len : chunk_bytes_left) - 16'd1;
    off_eff    = start ? off_b : line_offset;
    idx_eff    = start ? idx_b : line_index;
    marker_eff = start ? marker_new : chunk_marker;

    push_data.pixel      = pixel_byte;
    push_data.start      = start;
    push_data.last       = cl_after == 16'd0;
    push_data.frame_last = (cl_after == 16'd0) && marker_eff;
    push_data.marker     = marker_new;
    push_data.seq        = sequence_number;
    push_data.timestamp  = ts_new;
    push_data.len        = len;
    push_data.line       = idx_b[14:0];
    push_data.offset     = off_b[14:0];
  end

  assign push_valid  = pixel_valid;
  assign pixel_ready = push_ready;
  assign accept      = pixel_valid && push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_number   <= '0;
      line_index        <= '0;
      line_offset       <= '0;
      chunk_bytes_left  <= '0;
      latched_timestamp <= '0;
      chunk_marker      <= 1'b0;
    end else if (accept) begin
      chunk_bytes_left <= cl_after;
      line_offset      <= off_eff + 16'd1;
      line_index       <= idx_eff;
      if (start) begin
        latched_timestamp <= ts_new;
        sequence_number   <= sequence_number + 16'd1;
        chunk_marker      <= marker_new;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/rtpvp_queue.sv]
// ----------------------------------------------------------------------------
// rtpvp_queue
// Small register FIFO between the classifier and the packet writer.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpvp_queue #(
  parameter int unsigned DEPTH = rtpvp_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire rtpvp_pkg::cmd_t push_data,
  output logic                 pop_valid,
  input  wire logic            pop,
  output rtpvp_pkg::cmd_t      pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  rtpvp_pkg::cmd_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_push, do_pop;

  assign push_ready = count != CNT_FULL;
  assign pop_valid  = count != '0;
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/rtpvp_back.sv]
// ----------------------------------------------------------------------------
// rtpvp_back
// Writes the 20-byte RTP/RFC 4175 header ahead of chunk-opening bytes and
// drives the registered output word.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpvp_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire rtpvp_pkg::cfg_t cfg,
  input  wire logic            head_valid,
  input  wire rtpvp_pkg::cmd_t head,
  output logic                 pop,
  output logic                 packet_valid,
  input  wire logic            packet_ready,
  output logic [7:0]           packet_byte,
  output logic                 packet_end,
  output logic                 frame_end
);

  localparam int unsigned HDR_W = $clog2(rtpvp_pkg::HDR_LEN + 1);
  localparam logic [HDR_W-1:0] HDR_DONE = HDR_W'(rtpvp_pkg::HDR_LEN);

  logic [HDR_W-1:0] hdr_cnt;
  logic [7:0]       hdr_byte;
  logic             advance, in_header;

  always_comb begin
    case (hdr_cnt)
      HDR_W'(0):  hdr_byte = rtpvp_pkg::RTP_VERSION_BYTE;
      HDR_W'(1):  hdr_byte = {head.marker, cfg.payload_type};
      HDR_W'(2):  hdr_byte = head.seq[15:8];
      HDR_W'(3):  hdr_byte = head.seq[7:0];
      HDR_W'(4):  hdr_byte = head.timestamp[31:24];
      HDR_W'(5):  hdr_byte = head.timestamp[23:16];
      HDR_W'(6):  hdr_byte = head.timestamp[15:8];
      HDR_W'(7):  hdr_byte = head.timestamp[7:0];
      HDR_W'(8):  hdr_byte = cfg.sync_source_id[31:24];
      HDR_W'(9):  hdr_byte = cfg.sync_source_id[23:16];
      HDR_W'(10): hdr_byte = cfg.sync_source_id[15:8];
      HDR_W'(11): hdr_byte = cfg.sync_source_id[7:0];
      HDR_W'(14): hdr_byte = head.len[15:8];
      HDR_W'(15): hdr_byte = head.len[7:0];
      HDR_W'(16): hdr_byte = {1'b0, head.line[14:8]};
      HDR_W'(17): hdr_byte = head.line[7:0];
      HDR_W'(18): hdr_byte = {1'b0, head.offset[14:8]};
      HDR_W'(19): hdr_byte = head.offset[7:0];
      default:    hdr_byte = 8'h00;  // extended sequence
    endcase
  end

  assign advance   = !packet_valid || packet_ready;
  assign in_header = head.start && (hdr_cnt != HDR_DONE);
  assign pop       = advance && head_valid && !in_header;

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_valid <= 1'b0;
      hdr_cnt      <= '0;
    end else if (advance) begin
      packet_valid <= head_valid;
      if (head_valid) begin
        hdr_cnt <= in_header ? hdr_cnt + HDR_W'(1) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && head_valid) begin
      if (in_header) begin
        packet_byte <= hdr_byte;
        packet_end  <= 1'b0;
        frame_end   <= 1'b0;
      end else begin
        packet_byte <= head.pixel;
        packet_end  <= head.last;
        frame_end   <= head.frame_last;
      end
    end
  end

  a_hdr_cnt_range: assert property (@(posedge clk) disable iff (rst)
    hdr_cnt <= HDR_DONE)
    else $error("header counter out of range");

  a_hdr_needs_start: assert property (@(posedge clk) disable iff (rst)
    hdr_cnt != '0 |-> head_valid && head.start)
    else $error("header in progress without a chunk-opening word");

  a_frame_end_closes_packet: assert property (@(posedge clk) disable iff (rst)
    packet_valid && frame_end |-> packet_end)
    else $error("frame end on a word that does not close a packet");

  a_header_then_pixel: assert property (@(posedge clk) disable iff (rst)
    advance && head_valid && hdr_cnt == HDR_DONE |-> pop)
    else $error("completed header not followed by its payload byte");

endmodule

`default_nettype wire

[rtl/rtp_video_line_packetizer.sv]
// ----------------------------------------------------------------------------
// rtp_video_line_packetizer
// Cuts raster video bytes into RTP/RFC 4175 packets: one 20-byte header per
// chunk of a line, chunk size bounded by the MTU.
//
//   channel   signals                                   dir
//   pixel     pixel_valid/ready, pixel_byte, frame_time in
//   packet    packet_valid/ready, packet_byte,          out
//             packet_end, frame_end
//   cfg       cfg_valid/ready, cfg_index, cfg_data      in
//
// One input word per cycle inside a chunk while the queue has room; a
// chunk-opening word costs its 20-byte header plus the byte on the output port.
// The classifier-to-writer queue (QUEUE_DEPTH words) absorbs header time,
// so input stalls only once it fills. Output is registered; no bubbles
// when packet_ready stays high. Synchronous reset, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_video_line_packetizer #(
  parameter int unsigned QUEUE_DEPTH = rtpvp_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        pixel_valid,
  output logic             pixel_ready,
  input  wire logic [7:0]  pixel_byte,
  input  wire logic [31:0] frame_time,
  output logic             packet_valid,
  input  wire logic        packet_ready,
  output logic [7:0]       packet_byte,
  output logic             packet_end,
  output logic             frame_end,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  rtpvp_pkg::cfg_t cfg;
  rtpvp_pkg::cmd_t push_data, head;
  logic push_valid, push_ready, head_valid, pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.payload_type   <= rtpvp_pkg::RST_PAYLOAD_TYPE;
      cfg.sync_source_id <= rtpvp_pkg::RST_SSRC;
      cfg.mtu_bytes      <= rtpvp_pkg::RST_MTU_BYTES;
      cfg.line_bytes     <= rtpvp_pkg::RST_LINE_BYTES;
      cfg.frame_lines    <= rtpvp_pkg::RST_FRAME_LINES;
    end else if (cfg_valid) begin
      unique case (rtpvp_pkg::cfg_index_t'(cfg_index))
        rtpvp_pkg::CFG_PAYLOAD_TYPE: cfg.payload_type   <= cfg_data[6:0];
        rtpvp_pkg::CFG_SSRC:         cfg.sync_source_id <= cfg_data;
        rtpvp_pkg::CFG_MTU_BYTES:    cfg.mtu_bytes      <= cfg_data[15:0];
        rtpvp_pkg::CFG_LINE_BYTES:   cfg.line_bytes     <= cfg_data[15:0];
        rtpvp_pkg::CFG_FRAME_LINES:  cfg.frame_lines    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  rtpvp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel_byte  (pixel_byte),
    .frame_time  (frame_time),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  rtpvp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (head_valid),
    .pop        (pop),
    .pop_data   (head)
  );

  rtpvp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .packet_valid (packet_valid),
    .packet_ready (packet_ready),
    .packet_byte  (packet_byte),
    .packet_end   (packet_end),
    .frame_end    (frame_end)
  );

endmodule

`default_nettype wire

[bench/rtp_video_line_packetizer_test.sv]
// ----------------------------------------------------------------------------
// rtp_video_line_packetizer_test
// Self-checking bench for the RTP video line packetizer. A directed table
// (register extremes, degenerate line and frame sizes, unused register
// index, MTU at and above the payload threshold) is followed by random
// phases with fresh register settings. Every output word is checked against
// a shadow packetizer that builds the expected header and payload words.
// ----------------------------------------------------------------------------
module rtp_video_line_packetizer_test;

  localparam int NUM_PHASES      = 9;
  localparam int ITEMS_PER_PHASE = 49;
  localparam int SETTLE_CYCLES   = 8;
  localparam int DRAIN_LIMIT     = 20000;
  localparam int HOLD_CYCLES     = 300;
  localparam int MAX_REPORTS     = 50;
  localparam int unsigned CYCLE_LIMIT = 400000;

  localparam logic [2:0] CFG_SPARE_INDEX  = 3'd5;
  localparam logic [2:0] CFG_UNUSED_INDEX = 3'd7;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       frame_last;
  } packet_word_t;

  typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_t;

  typedef struct packed {
    row_kind_t    kind;
    logic [2:0]   idx;
    logic [31:0]  value;
    logic [7:0]   pix;
    logic [31:0]  stamp;
    logic         typed;
    packet_word_t word;
  } row_t;

  localparam packet_word_t NO_WORD = '0;
  localparam int NUM_ROWS = 40;

  // typed words: single-byte lines in single-line frames close both packet and frame
  localparam row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{ROW_WRITE, CFG_UNUSED_INDEX,            32'hFFFF_FFFF, 8'h00, 32'h0, 1'b0, NO_WORD},
    '{ROW_WRITE, rtpvp_pkg::CFG_LINE_BYTES,   32'h0000_0000, 8'h00, 32'h0, 1'b0, NO_WORD},
    '{ROW_WRITE, rtpvp_pkg::CFG_FRAME_LINES,  32'h0000_0000, 8'h00, 32'h0, 1'b0, NO_WORD},
    '{ROW_WRITE, rtpvp_pkg::CFG_MTU_BYTES,    32'h0000_0000, 8'h00, 32'h0, 1'b0, NO_WORD},
    '{ROW_PIXEL, 3'd0, 32'h0, 8'h00, 32'h0000_0000, 1'b1, '{8'h00, 1'b1, 1'b1}},
    '{ROW_PIXEL, 3'd0, 32'h0, 8'hFF, 32'hFFFF_FFFF, 1'b1, '{8'hFF, 1'b1, 1'b1}},
    '{ROW_WRITE, rtpvp_pkg::CFG_PAYLOAD_TYPE, 32'hFFFF_FFFF, 8'h00, 32'h0, 1'b0, NO_WORD},
    '{ROW_WRITE, rtpvp_pkg::CFG_SSRC,         32'hFFFF_FFFF, 8'h00, 32'h0, 1'b0, NO_WORD},
    '{ROW_PIXEL, 3'd0, 32'h0, 8'hA5, 32'hA5A5_A5A5, 1'b1, '{8'hA5, 1'b1, 1'b1}},
    '{ROW_WRITE, rtpvp_pkg::CFG_PAYLOAD_TYPE, 32'h0000_0000, 8'h00, 32'h0, 1'b0, NO_WORD},
    '{ROW_WRITE, rtpvp_pkg::CFG_SSRC,         32'h0000_0000, 8'h00, 32'h0, 1'b0, NO_WORD},
    '{ROW_WRITE, CFG_SPARE_INDEX,             32'h0000_0000, 8'h00, 32'h0, 1'b0, NO_WORD},
    '{ROW_PIXEL, 3'd0, 32'h0, 8'h5A, 32'h5A5A_5A5A, 1'b1, '{8'h5A, 1'b1, 1'b1}},
    '{ROW_WRITE, rtpvp_pkg::CFG_MTU_BYTES,    32'h0000_0028, 8'h00, 32'h0, 1'b0, NO_WORD},
    '{ROW_WRITE, rtpvp_pkg::CFG_LINE_BYTES,   32'h0000_0003, 8'h00, 32'h0, 1'b0, NO_WORD},
    '{ROW_WRITE, rtpvp_pkg::CFG_FRAME_LINES,  32'h0000_0002, 8'h00, 32'h0, 1'b0, NO_WORD},
    '{ROW_PIXEL, 3'd0, 32'h0, 8'h01, 32'h0000_0001, 1'b0, NO_WORD},
    '{ROW_PIXEL, 3'd0, 32'h0, 8'h02, 32'h0000_0002, 1'b0, NO_WORD},
    '{ROW_PIXEL, 3'd0, 32'h0, 8'h04, 32'h0000_0004, 1'b0, NO_WORD},
    '{ROW_PIXEL, 3'd0, 32'h0, 8'h08, 32'h0000_0008, 1'b0, NO_WORD},
    '{ROW_PIXEL, 3'd0, 32'h0, 8'h10, 32'h0000_0010, 1'b0, NO_WORD},
    '{ROW_PIXEL, 3'd0, 32'h0, 8'h20, 32'h0000_0020, 1'b0, NO_WORD},
    '{ROW_WRITE, rtpvp_pkg::CFG_MTU_BYTES,    32'h0000_0029, 8'h00, 32'h0, 1'b0, NO_WORD},
    '{ROW_WRITE, rtpvp_pkg::CFG_LINE_BYTES,   32'h0000_000B, 8'h00, 32'h0, 1'b0, NO_WORD},
    '{ROW_PIXEL, 3'd0, 32'h0, 8'h40, 32'h1234_5678, 1'b0, NO_WORD},
    '{ROW_PIXEL, 3'd0, 32'h0, 8'h80, 32'h1234_5678, 1'b0, NO_WORD},
    '{ROW_PIXEL, 3'd0, 32'h0, 8'hC3, 32'h1234_5678, 1'b0, NO_WORD},
    '{ROW_PIXEL, 3'd0, 32'h0, 8'h3C, 32'h1234_5678, 1'b0, NO_WORD},
    '{ROW_PIXEL, 3'd0, 32'h0, 8'h99, 32'h1234_5678, 1'b0, NO_WORD},
    '{ROW_PIXEL, 3'd0, 32'h0, 8'h66, 32'h1234_5678, 1'b0, NO_WORD},
    '{ROW_PIXEL, 3'd0, 32'h0, 8'hE7, 32'h8765_4321, 1'b0, NO_WORD},
    '{ROW_PIXEL, 3'd0, 32'h0, 8'h7E, 32'h8765_4321, 1'b0, NO_WORD},
    '{ROW_PIXEL, 3'd0, 32'h0, 8'h11, 32'h8765_4321, 1'b0, NO_WORD},
    '{ROW_PIXEL, 3'd0, 32'h0, 8'h22, 32'h8765_4321, 1'b0, NO_WORD},
    '{ROW_PIXEL, 3'd0, 32'h0, 8'h33, 32'h8765_4321, 1'b0, NO_WORD},
    '{ROW_WRITE, rtpvp_pkg::CFG_MTU_BYTES,    32'hFFFF_FFFF, 8'h00, 32'h0, 1'b0, NO_WORD},
    '{ROW_WRITE, rtpvp_pkg::CFG_LINE_BYTES,   32'hFFFF_FFFF, 8'h00, 32'h0, 1'b0, NO_WORD},
    '{ROW_WRITE, rtpvp_pkg::CFG_FRAME_LINES,  32'hFFFF_FFFF, 8'h00, 32'h0, 1'b0, NO_WORD},
    '{ROW_PIXEL, 3'd0, 32'h0, 8'h81, 32'h8000_0000, 1'b0, NO_WORD},
    '{ROW_PIXEL, 3'd0, 32'h0, 8'h7F, 32'h7FFF_FFFF, 1'b0, NO_WORD}
  };

  logic        clk;
  logic        rst          = 1'b1;
  logic        pixel_valid  = 1'b0;
  logic        pixel_ready;
  logic [7:0]  pixel_byte   = '0;
  logic [31:0] frame_time   = '0;
  logic        packet_valid;
  logic        packet_ready = 1'b0;
  logic [7:0]  packet_byte;
  logic        packet_end;
  logic        frame_end;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index    = '0;
  logic [31:0] cfg_data     = '0;

  int          sender_idle_pct = 0;
  int          rx_idle_pct     = 0;
  bit          hold_output     = 1'b0;
  int          mismatches      = 0;
  int unsigned cycle_count     = 0;

  // shadow of the block: registers and packetizer state
  rtpvp_pkg::cfg_t regs = '{rtpvp_pkg::RST_PAYLOAD_TYPE, rtpvp_pkg::RST_SSRC,
                            rtpvp_pkg::RST_MTU_BYTES, rtpvp_pkg::RST_LINE_BYTES,
                            rtpvp_pkg::RST_FRAME_LINES};
  logic [15:0] next_seq    = '0;
  logic [15:0] cur_line    = '0;
  logic [15:0] cur_pos     = '0;
  logic [15:0] bytes_to_go = '0;
  logic [31:0] stamp_latch = '0;
  logic        closes_frame = 1'b0;

  packet_word_t expected_words [$];

  rtp_video_line_packetizer i_dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel_byte   (pixel_byte),
    .frame_time   (frame_time),
    .packet_valid (packet_valid),
    .packet_ready (packet_ready),
    .packet_byte  (packet_byte),
    .packet_end   (packet_end),
    .frame_end    (frame_end),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("rtp_video_line_packetizer test failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t mismatch: %s", $time, msg);
    end
  endtask

  task automatic expect_word(input packet_word_t w);
    expected_words = {expected_words, w};
  endtask

  task automatic predict_packet_words(input logic [7:0] pix, input logic [31:0] stamp);
    logic [15:0]  lb;
    logic [15:0]  fl;
    logic [15:0]  limit;
    logic [15:0]  room;
    logic [15:0]  len;
    logic [159:0] hdr;
    lb = (regs.line_bytes == 16'd0) ? 16'd1 : regs.line_bytes;
    fl = (regs.frame_lines == 16'd0) ? 16'd1 : regs.frame_lines;
    if (bytes_to_go == 16'd0) begin
      limit = (regs.mtu_bytes > rtpvp_pkg::MTU_MIN_BYTES) ?
              regs.mtu_bytes - rtpvp_pkg::MTU_OVERHEAD : rtpvp_pkg::DEFAULT_PAYLOAD;
      if (cur_pos >= lb) begin
        cur_pos  = '0;
        cur_line = cur_line + 16'd1;
      end
      if (cur_line >= fl) begin
        cur_line = '0;
        cur_pos  = '0;
      end
      if (cur_line == 16'd0 && cur_pos == 16'd0) begin
        stamp_latch = stamp;
      end
      room = lb - cur_pos;
      len  = (room < limit) ? room : limit;
      closes_frame = (cur_line == fl - 16'd1) && (room == len);
      hdr = {rtpvp_pkg::RTP_VERSION_BYTE, closes_frame, regs.payload_type, next_seq,
             stamp_latch, regs.sync_source_id, 16'h0000, len, 1'b0, cur_line[14:0],
             1'b0, cur_pos[14:0]};
      for (int i = rtpvp_pkg::HDR_LEN - 1; i >= 0; i--) begin
        expect_word(packet_word_t'{hdr[i*8 +: 8], 1'b0, 1'b0});
      end
      next_seq    = next_seq + 16'd1;
      bytes_to_go = len;
    end
    bytes_to_go = bytes_to_go - 16'd1;
    cur_pos     = cur_pos + 16'd1;
    expect_word(packet_word_t'{pix, bytes_to_go == 16'd0,
                               bytes_to_go == 16'd0 && closes_frame});
  endtask

  // called at a rising edge; returns at the edge that takes the word
  task automatic push_pixel(input logic [7:0] pix, input logic [31:0] stamp);
    if ($urandom_range(99) < sender_idle_pct) begin
      pixel_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    pixel_valid <= 1'b1;
    pixel_byte  <= pix;
    frame_time  <= stamp;
    do @(negedge clk); while (!pixel_ready);
    predict_packet_words(pix, stamp);
    @(posedge clk);
  endtask

  task automatic drain_packets();
    int waited;
    waited = 0;
    pixel_valid <= 1'b0;
    while (expected_words.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_words.size() != 0) begin
      report_mismatch($sformatf("%0d expected words never came out",
                                expected_words.size()));
      expected_words.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    drain_packets();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (!cfg_ready);
    case (idx)
      rtpvp_pkg::CFG_PAYLOAD_TYPE: regs.payload_type   = data[6:0];
      rtpvp_pkg::CFG_SSRC:         regs.sync_source_id = data;
      rtpvp_pkg::CFG_MTU_BYTES:    regs.mtu_bytes      = data[15:0];
      rtpvp_pkg::CFG_LINE_BYTES:   regs.line_bytes     = data[15:0];
      rtpvp_pkg::CFG_FRAME_LINES:  regs.frame_lines    = data[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_output) begin
        packet_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
      end
      packet_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(negedge clk) begin : word_check
    packet_word_t want;
    if (!rst && packet_valid && packet_ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("packet word %02h with nothing expected", packet_byte));
      end else begin
        want = expected_words.pop_front();
        if (packet_byte !== want.data) begin
          report_mismatch($sformatf("packet_byte %02h, expected %02h",
                                    packet_byte, want.data));
        end
        if (packet_end !== want.last) begin
          report_mismatch($sformatf("packet_end %0b, expected %0b",
                                    packet_end, want.last));
        end
        if (frame_end !== want.frame_last) begin
          report_mismatch($sformatf("frame_end %0b, expected %0b",
                                    frame_end, want.frame_last));
        end
      end
    end
  end

  initial begin : stimulus
    logic [15:0] mtu;
    logic [15:0] lb;
    logic [15:0] fl;
    logic [31:0] stamp;

    sender_idle_pct = 28;
    rx_idle_pct     = 52;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < NUM_ROWS; r++) begin
      if (DIRECTED_ROWS[r].kind == ROW_WRITE) begin
        write_reg(DIRECTED_ROWS[r].idx, DIRECTED_ROWS[r].value);
      end else begin
        push_pixel(DIRECTED_ROWS[r].pix, DIRECTED_ROWS[r].stamp);
        if (DIRECTED_ROWS[r].typed) begin
          expected_words[expected_words.size() - 1] = DIRECTED_ROWS[r].word;
        end
      end
    end

    stamp = $urandom();
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      sender_idle_pct = (ph < 3) ? 28 : (ph < 6) ? 52 : 0;
      rx_idle_pct     = (ph < 3) ? 52 : (ph < 6) ? 28 : 0;

      case ($urandom_range(5))
        0:       mtu = 16'($urandom_range(40));
        1, 2:    mtu = 16'($urandom_range(72, 41));
        3:       mtu = 16'hFFFF;
        default: mtu = 16'($urandom_range(1500, 73));
      endcase
      case ($urandom_range(5))
        0:       lb = 16'd0;
        1:       lb = 16'd1;
        2, 3:    lb = 16'($urandom_range(48, 2));
        4:       lb = 16'($urandom_range(300, 49));
        default: lb = 16'hFFFF;
      endcase
      case ($urandom_range(5))
        0:       fl = 16'd0;
        1:       fl = 16'd1;
        2, 3:    fl = 16'($urandom_range(6, 2));
        4:       fl = 16'($urandom_range(40, 7));
        default: fl = 16'hFFFF;
      endcase

      write_reg(rtpvp_pkg::CFG_PAYLOAD_TYPE, $urandom());
      write_reg(rtpvp_pkg::CFG_SSRC, $urandom());
      write_reg(rtpvp_pkg::CFG_MTU_BYTES, {16'($urandom()), mtu});
      write_reg(rtpvp_pkg::CFG_LINE_BYTES, {16'($urandom()), lb});
      write_reg(rtpvp_pkg::CFG_FRAME_LINES, {16'($urandom()), fl});
      if ($urandom_range(3) == 0) begin
        write_reg(CFG_UNUSED_INDEX, $urandom());
      end

      // long output stall with the source running flat out
      if (ph == 6) begin
        hold_output = 1'b1;
      end

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(15) == 0) begin
          stamp = $urandom();
        end
        push_pixel(8'($urandom_range(255)), stamp);
      end
    end

    drain_packets();
    if (mismatches == 0) begin
      $display("rtp_video_line_packetizer test passed");
    end else begin
      $display("rtp_video_line_packetizer test failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/rtpvp_pkg.sv
rtl/rtpvp_front.sv
rtl/rtpvp_queue.sv
rtl/rtpvp_back.sv
rtl/rtp_video_line_packetizer.sv
bench/rtp_video_line_packetizer_test.sv
